// ----- design/ax25rx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AX.25 receive parser package
// Shared widths, field and status codes, the result record and the
// reflected CRC-16-CCITT byte update.
// ----------------------------------------------------------------------------
package ax25rx_pkg;

  localparam int POS_BITS = 12;

  localparam logic [POS_BITS-1:0] POS_MAX        = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] CTRL_POS_INIT  = 12'd14;
  localparam logic [POS_BITS:0]   ADDR_STEP      = 13'd7;
  localparam logic [POS_BITS:0]   CTRL_PID_LEN   = 13'd4;
  localparam logic [POS_BITS:0]   MIN_FRAME_LEN  = 13'd17;
  localparam logic [11:0]         PAYLOAD_LIMIT  = 12'd2048;
  localparam logic [11:0]         PAYLOAD_RESET  = 12'd256;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam logic [2:0] KIND_DST_CHAR = 3'd0;
  localparam logic [2:0] KIND_DST_SSID = 3'd1;
  localparam logic [2:0] KIND_SRC_CHAR = 3'd2;
  localparam logic [2:0] KIND_SRC_SSID = 3'd3;
  localparam logic [2:0] KIND_DIGI     = 3'd4;
  localparam logic [2:0] KIND_CONTROL  = 3'd5;
  localparam logic [2:0] KIND_PID      = 3'd6;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd7;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_SHORT     = 3'd1;
  localparam logic [2:0] STAT_FCS_ERR   = 3'd2;
  localparam logic [2:0] STAT_ADDR_OVR  = 3'd3;
  localparam logic [2:0] STAT_PAY_LONG  = 3'd4;

  typedef struct packed {
    logic       has_element;
    logic [2:0] kind;
    logic [7:0] value;
    logic       frame_end;
    logic [2:0] status;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/ax25_frame_receive_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AX.25 frame receive parser
// Receives frame bytes including the FCS, tags each address, control, PID
// and payload byte, checks the CRC-16-CCITT FCS and closes every frame with
// a status.
//
// The in_ channel takes one frame byte per transaction, with in_tlast on the
// final byte. Each byte is released two positions later, so the two FCS
// bytes are never tagged. A transaction that releases a byte or ends a frame
// produces one out_ transaction; the first two bytes of a frame produce none
// unless the frame ends there. The closing transaction carries out_tlast and
// the status together with the last released byte of that frame, so a consumer
// drops the payload on a nonzero status.
// An accepted byte's result is registered in the output register, or in the one
// skid entry while a full output register waits on out_tready; one byte can be
// accepted every cycle while the skid entry is free, and the CRC update and
// classification finish in the accepting cycle. in_tready falls only when the skid entry is occupied.
// Reset (rst_n low, synchronous) clears the frame state, empties the output
// stages and sets max_payload to 256. cfg_wr_en writes max_payload.
// ----------------------------------------------------------------------------
module ax25_frame_receive_parser
  import ax25rx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,   // max_payload
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tlast,      // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [7:0] value, [10:8] status, [15:11] zero
  output logic [3:0]  out_tuser,     // [0] has_element, [3:1] kind
  output logic        out_tlast      // frame_end
);

  logic    in_fire;
  logic    res_vld;
  result_t res;
  result_t out_r;
  logic    out_vld_r;
  result_t skid_r;
  logic    skid_vld_r;

  assign in_tready = !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;

  ax25rx_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .data_byte   (in_tdata),
    .last_byte   (in_tlast),
    .res_vld     (res_vld),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_tready) begin
      if (res_vld) begin
        skid_vld_r <= 1'b1;
        skid_r     <= res;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      out_r      <= skid_r;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= res_vld;
      out_r     <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b00000, out_r.status, out_r.value};
  assign out_tuser  = {out_r.kind, out_r.has_element};
  assign out_tlast  = out_r.frame_end;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry occupied while output register is empty");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[10:8] == STAT_OK))
    else $error("status set on a transaction that does not close a frame");

  a_empty_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("transaction without element that does not close a frame");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:8] <= STAT_PAY_LONG))
    else $error("status code out of range");
`endif

endmodule

// ----- design/ax25rx_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AX.25 receive parser core
// Per-frame state, two-byte hold-back, byte classification, CRC update and
// the frame status decision, all settled in the cycle a byte is accepted.
// ----------------------------------------------------------------------------
module ax25rx_parse
  import ax25rx_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [11:0]   cfg_wr_data,
  input  logic          in_fire,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output logic          res_vld,
  output result_t       res
);

  logic [11:0]         max_payload_r;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [7:0]          dly0_r, dly0_nxt;
  logic [7:0]          dly1_r, dly1_nxt;
  logic                dig_seen_r, dig_seen_nxt;
  logic [POS_BITS-1:0] ctrl_pos_r, ctrl_pos_nxt;
  logic                addr_open_r, addr_open_nxt;

  logic                has;
  logic [POS_BITS-1:0] rpos;
  logic [POS_BITS:0]   rpos_ext;
  logic [POS_BITS:0]   cp_ext;
  logic [POS_BITS:0]   cp_step;
  logic [2:0]          kind;
  logic [7:0]          value;
  logic [15:0]         crc_upd;
  logic [POS_BITS-1:0] cp_upd;
  logic                dig_upd;
  logic                open_upd;
  logic [POS_BITS:0]   len;
  logic [POS_BITS:0]   cp_upd_ext;
  logic [POS_BITS:0]   pay_len;
  logic [11:0]         limit;
  logic [15:0]         rx_fcs;
  logic [2:0]          status;

  always_comb begin
    has      = (pos_r >= 12'd2);
    rpos     = pos_r - 12'd2;
    rpos_ext = {1'b0, rpos};
    cp_ext   = {1'b0, ctrl_pos_r};

    if (rpos < 12'd6) begin
      kind = KIND_DST_CHAR;
    end else if (rpos == 12'd6) begin
      kind = KIND_DST_SSID;
    end else if (rpos < 12'd13) begin
      kind = KIND_SRC_CHAR;
    end else if (rpos == 12'd13) begin
      kind = KIND_SRC_SSID;
    end else if (rpos < ctrl_pos_r) begin
      kind = KIND_DIGI;
    end else if (rpos == ctrl_pos_r) begin
      kind = KIND_CONTROL;
    end else if (rpos_ext == cp_ext + 13'd1) begin
      kind = KIND_PID;
    end else begin
      kind = KIND_PAYLOAD;
    end

    case (kind)
      KIND_DST_CHAR, KIND_SRC_CHAR: value = {1'b0, dly0_r[7:1]};
      KIND_DST_SSID, KIND_SRC_SSID: value = {4'h0, dly0_r[4:1]};
      default:                      value = dly0_r;
    endcase

    if (!has) begin
      kind  = KIND_DST_CHAR;
      value = 8'h00;
    end

    crc_upd  = has ? crc_byte(crc_r, dly0_r) : crc_r;
    cp_upd   = ctrl_pos_r;
    dig_upd  = dig_seen_r;
    open_upd = addr_open_r;
    cp_step  = cp_ext + ADDR_STEP;
    if (has && addr_open_r && (rpos_ext + 13'd1 == cp_ext)) begin
      if (dly0_r[0]) begin
        open_upd = 1'b0;
      end else begin
        cp_upd  = cp_step[POS_BITS] ? POS_MAX : cp_step[POS_BITS-1:0];
        dig_upd = 1'b1;
      end
    end

    len        = {1'b0, pos_r} + 13'd1;
    cp_upd_ext = {1'b0, cp_upd};
    pay_len    = len - cp_upd_ext - CTRL_PID_LEN;
    limit      = (max_payload_r < PAYLOAD_LIMIT) ? max_payload_r : PAYLOAD_LIMIT;
    rx_fcs     = {data_byte, dly1_r};

    if (len < MIN_FRAME_LEN) begin
      status = STAT_SHORT;
    end else if (rx_fcs != ~crc_upd) begin
      status = STAT_FCS_ERR;
    end else if (dig_upd && (cp_upd_ext + ADDR_STEP >= len)) begin
      status = STAT_ADDR_OVR;
    end else if ((len < cp_upd_ext + CTRL_PID_LEN) || (pay_len > {1'b0, limit})) begin
      status = STAT_PAY_LONG;
    end else begin
      status = STAT_OK;
    end

    dly0_nxt = dly1_r;
    dly1_nxt = data_byte;
    if (last_byte) begin
      pos_nxt       = '0;
      crc_nxt       = CRC_INIT;
      dig_seen_nxt  = 1'b0;
      ctrl_pos_nxt  = CTRL_POS_INIT;
      addr_open_nxt = 1'b1;
    end else begin
      pos_nxt       = (pos_r == POS_MAX) ? POS_MAX : pos_r + 12'd1;
      crc_nxt       = crc_upd;
      dig_seen_nxt  = dig_upd;
      ctrl_pos_nxt  = cp_upd;
      addr_open_nxt = open_upd;
    end

    res_vld         = in_fire && (has || last_byte);
    res.has_element = has;
    res.kind        = kind;
    res.value       = value;
    res.frame_end   = last_byte;
    res.status      = last_byte ? status : STAT_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= PAYLOAD_RESET;
      pos_r         <= '0;
      crc_r         <= CRC_INIT;
      dly0_r        <= 8'h00;
      dly1_r        <= 8'h00;
      dig_seen_r    <= 1'b0;
      ctrl_pos_r    <= CTRL_POS_INIT;
      addr_open_r   <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        max_payload_r <= cfg_wr_data;
      end
      if (in_fire) begin
        pos_r       <= pos_nxt;
        crc_r       <= crc_nxt;
        dly0_r      <= dly0_nxt;
        dly1_r      <= dly1_nxt;
        dig_seen_r  <= dig_seen_nxt;
        ctrl_pos_r  <= ctrl_pos_nxt;
        addr_open_r <= addr_open_nxt;
      end
    end
  end

endmodule
